// File: sv/ccmp_pkg.sv
`default_nettype none
package ccmp_pkg;

   localparam int PN_W      = 48;
   localparam int HDR_W     = 64;
   localparam int CNT_W     = 32;
   localparam int KID_W     = 2;
   localparam int EXTIV_POS = 5;
   localparam int KID_SHIFT = 6;

   localparam logic [1:0] REQ_TX    = 2'd0;
   localparam logic [1:0] REQ_RX    = 2'd1;
   localparam logic [1:0] REQ_REKEY = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
   localparam logic [2:0] ST_NO_EXTIV   = 3'd2;
   localparam logic [2:0] ST_KEY_MISM   = 3'd3;
   localparam logic [2:0] ST_NO_KEY     = 3'd4;
   localparam logic [2:0] ST_REPLAY     = 3'd5;
   localparam logic [2:0] ST_MIC_FAIL   = 3'd6;
   localparam logic [2:0] ST_TX_NO_ROOM = 3'd7;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [HDR_W-1:0] rx_header;
      logic             frame_long_enough;
      logic             mic_ok;
      logic             key_present;
      logic [PN_W-1:0]  seed_pn;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [HDR_W-1:0] tx_header;
      logic [PN_W-1:0]  packet_number;
      logic [KID_W-1:0] frame_key_index;
      logic [CNT_W-1:0] format_error_count;
      logic [CNT_W-1:0] replay_count;
      logic [CNT_W-1:0] decrypt_error_count;
   } rsp_type;

endpackage
`default_nettype wire

// File: sv/ccmp_pn_unit.sv
`default_nettype none
module ccmp_pn_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire ccmp_pkg::req_type      req,
   input  wire logic [1:0]             key_index,
   output ccmp_pkg::rsp_type           rsp
);
   import ccmp_pkg::*;

   logic [PN_W-1:0]  tx_pn_ff, tx_pn_in;
   logic [PN_W-1:0]  rx_pn_ff, rx_pn_in;
   logic             key_valid_ff, key_valid_in;
   logic [CNT_W-1:0] fmt_cnt_ff, fmt_cnt_in;
   logic [CNT_W-1:0] rpl_cnt_ff, rpl_cnt_in;
   logic [CNT_W-1:0] dec_cnt_ff, dec_cnt_in;

   logic [7:0]       kid_octet;
   logic [PN_W-1:0]  rx_pn_parsed;
   logic [PN_W-1:0]  tx_pn_next;
   logic [31:0]      hi_new, hi_old, hi_diff;
   logic [15:0]      lo_new, lo_old;
   logic             replay;

   assign kid_octet    = req.rx_header[31:24];
   assign rx_pn_parsed = {req.rx_header[63:32], req.rx_header[15:0]};
   assign tx_pn_next   = tx_pn_ff + PN_W'(1);
   assign hi_new       = rx_pn_parsed[47:16];
   assign hi_old       = rx_pn_ff[47:16];
   assign lo_new       = rx_pn_parsed[15:0];
   assign lo_old       = rx_pn_ff[15:0];
   assign hi_diff      = hi_new - hi_old;
   assign replay       = hi_diff[31] || ((hi_new == hi_old) && (lo_new <= lo_old));

   always_comb begin
      tx_pn_in     = tx_pn_ff;
      rx_pn_in     = rx_pn_ff;
      key_valid_in = key_valid_ff;
      fmt_cnt_in   = fmt_cnt_ff;
      rpl_cnt_in   = rpl_cnt_ff;
      dec_cnt_in   = dec_cnt_ff;
      rsp.status          = ST_OK;
      rsp.tx_header       = '0;
      rsp.packet_number   = '0;
      rsp.frame_key_index = '0;
      case (req.req_type)
         REQ_TX: begin
            if (!req.frame_long_enough) begin
               rsp.status = ST_TX_NO_ROOM;
            end else begin
               tx_pn_in          = tx_pn_next;
               rsp.packet_number = tx_pn_next;
               rsp.tx_header     = {tx_pn_next[47:16], key_index, 1'b1,
                                    5'd0, 8'd0, tx_pn_next[15:0]};
            end
         end
         REQ_RX: begin
            rsp.packet_number   = rx_pn_parsed;
            rsp.frame_key_index = kid_octet[7:KID_SHIFT];
            if (!req.frame_long_enough) begin
               rsp.status = ST_TOO_SHORT;
               fmt_cnt_in = fmt_cnt_ff + CNT_W'(1);
            end else if (!kid_octet[EXTIV_POS]) begin
               rsp.status = ST_NO_EXTIV;
               fmt_cnt_in = fmt_cnt_ff + CNT_W'(1);
            end else if (kid_octet[7:KID_SHIFT] != key_index) begin
               rsp.status = ST_KEY_MISM;
            end else if (!key_valid_ff) begin
               rsp.status = ST_NO_KEY;
            end else if (replay) begin
               rsp.status = ST_REPLAY;
               rpl_cnt_in = rpl_cnt_ff + CNT_W'(1);
            end else if (!req.mic_ok) begin
               rsp.status = ST_MIC_FAIL;
               dec_cnt_in = dec_cnt_ff + CNT_W'(1);
            end else begin
               rx_pn_in = rx_pn_parsed;
            end
         end
         REQ_REKEY: begin
            tx_pn_in          = '0;
            fmt_cnt_in        = '0;
            rpl_cnt_in        = '0;
            dec_cnt_in        = '0;
            key_valid_in      = req.key_present;
            rx_pn_in          = req.key_present ? req.seed_pn : '0;
            rsp.packet_number = rx_pn_in;
         end
         default: begin
         end
      endcase
      rsp.format_error_count  = fmt_cnt_in;
      rsp.replay_count        = rpl_cnt_in;
      rsp.decrypt_error_count = dec_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_pn_ff     <= '0;
         rx_pn_ff     <= '0;
         key_valid_ff <= 1'b0;
         fmt_cnt_ff   <= '0;
         rpl_cnt_ff   <= '0;
         dec_cnt_ff   <= '0;
      end else if (fire) begin
         tx_pn_ff     <= tx_pn_in;
         rx_pn_ff     <= rx_pn_in;
         key_valid_ff <= key_valid_in;
         fmt_cnt_ff   <= fmt_cnt_in;
         rpl_cnt_ff   <= rpl_cnt_in;
         dec_cnt_ff   <= dec_cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/ccmp_header_pn_replay_engine.sv
// A transaction accepted into the input register moves into the result register once that
// register is empty or being drained by rsp_ready; the PN and counter state updates at the
// same edge that loads the result register.
// Throughput: one transaction per cycle while rsp_ready keeps the result register draining.
// Reset (synchronous, active high) clears both packet numbers, the key-valid flag,
// the three statistics counters, the key index and both valid flags.
`default_nettype none
module ccmp_header_pn_replay_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ccmp_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ccmp_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_wr_data
);
   import ccmp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff;
   logic [1:0] key_index_ff;
   logic       advance;
   rsp_type    rsp_next;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_data_ff;

   ccmp_pn_unit u_pn (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .req       (in_data_ff),
      .key_index (key_index_ff),
      .rsp       (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         key_index_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            key_index_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   a_adv_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after advance");

   a_no_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_TX_NO_ROOM) |->
      (rsp_payload.tx_header == '0 && rsp_payload.packet_number == '0))
      else $error("no-room result carries header or PN");

   a_rx_fail_no_hdr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OK && rsp_payload.status != ST_TX_NO_ROOM)
      |-> rsp_payload.tx_header == '0)
      else $error("receive failure carries transmit header");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input stage dropped a transaction");

endmodule
`default_nettype wire
